// ----- rtl/cck_pkg.sv -----
`default_nettype none
package cck_pkg;

  localparam int NUM_CFG     = 8;
  localparam int CFG_IDX_W   = $clog2(NUM_CFG);
  localparam int NUM_WORDS   = 16;
  localparam int ROUNDS      = 20;
  localparam int ROUND_W     = $clog2(ROUNDS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int DATA_W      = 64;
  localparam int DATA_BYTES  = DATA_W / 8;
  localparam int COUNT_W     = 4;
  localparam int WIDX_W      = 3;

  typedef logic [NUM_WORDS-1:0][31:0]     state_t;
  typedef logic [NUM_CFG-1:0][DATA_W-1:0] cfg_regs_t;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_CIPHER  = 2'd1,
    OP_PERMUTE = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] data;
    logic [COUNT_W-1:0] count;
    logic [WIDX_W-1:0] widx;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [31:0] rotl(logic [31:0] v, int k);
    return (v << k) | (v >> (32 - k));
  endfunction

  // One column round or one diagonal round: four independent quarter rounds.
  function automatic state_t chacha_round(state_t s, logic diag);
    state_t      r;
    logic [1:0]  ai, bi, ci, di;
    logic [31:0] a, b, c, d;
    r = s;
    for (int i = 0; i < 4; i++) begin
      ai = 2'(i);
      bi = diag ? 2'(i + 1) : 2'(i);
      ci = diag ? 2'(i + 2) : 2'(i);
      di = diag ? 2'(i + 3) : 2'(i);
      a  = s[{2'b00, ai}];
      b  = s[{2'b01, bi}];
      c  = s[{2'b10, ci}];
      d  = s[{2'b11, di}];
      a  = a + b; d = rotl(d ^ a, 16);
      c  = c + d; b = rotl(b ^ c, 12);
      a  = a + b; d = rotl(d ^ a, 8);
      c  = c + d; b = rotl(b ^ c, 7);
      r[{2'b00, ai}] = a;
      r[{2'b01, bi}] = b;
      r[{2'b10, ci}] = c;
      r[{2'b11, di}] = d;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/cck_front.sv -----
`default_nettype none
module cck_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_command,
  input  wire logic [63:0]                 in_data_in,
  input  wire logic [3:0]                  in_byte_count,
  input  wire logic                        in_first_of_message,
  input  wire cck_pkg::q_status_t          q_stat,
  output logic                             q_push,
  output cck_pkg::q_item_t                 q_item
);
  import cck_pkg::*;

  logic [WIDX_W-1:0] widx_r, widx_nxt, idx;

  always_comb begin
    in_stall = q_stat.full;
    q_push   = in_valid && !q_stat.full;
    idx      = in_first_of_message ? '0 : widx_r;
    q_item.data  = in_data_in;
    q_item.count = in_byte_count;
    q_item.widx  = idx;
    if (!in_command) begin
      q_item.op = OP_LOAD;
      widx_nxt  = '0;
    end else begin
      q_item.op = (idx == '0) ? OP_PERMUTE : OP_CIPHER;
      widx_nxt  = idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r <= '0;
    end else if (q_push) begin
      widx_r <= widx_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cck_queue.sv -----
`default_nettype none
module cck_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire cck_pkg::q_item_t   push_item,
  input  wire logic               pop,
  output cck_pkg::q_item_t        head,
  output cck_pkg::q_status_t      stat
);
  import cck_pkg::*;

  q_item_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  always_comb begin
    head       = mem[rd_r];
    stat.full  = (cnt_r == (QPTR_W + 1)'(QUEUE_DEPTH));
    stat.empty = (cnt_r == '0);
    cnt_nxt    = cnt_r + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cck_back.sv -----
`default_nettype none
module cck_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cck_pkg::cfg_regs_t  cfg_regs,
  input  wire cck_pkg::q_item_t    head,
  input  wire cck_pkg::q_status_t  q_stat,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [63:0]              out_data_out,
  output logic [3:0]               out_valid_bytes
);
  import cck_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROUND,
    S_EMIT
  } fsm_t;

  fsm_t               fsm_r;
  logic [ROUND_W-1:0] rnd_r;
  state_t             state_r;
  logic               out_valid_r;
  logic [DATA_W-1:0]  out_data_r;
  logic [COUNT_W-1:0] out_bytes_r;
  logic               out_free;
  logic [DATA_W-1:0]  ks, dout;

  always_comb begin
    out_free = !out_valid_r || !out_stall;
    ks       = {state_r[{head.widx, 1'b1}], state_r[{head.widx, 1'b0}]};
    for (int i = 0; i < DATA_BYTES; i++) begin
      dout[8*i +: 8] = head.data[8*i +: 8]
                     ^ ((head.count > COUNT_W'(i)) ? ks[8*i +: 8] : 8'h00);
    end
    q_pop = 1'b0;
    case (fsm_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          case (head.op)
            OP_LOAD:   q_pop = 1'b1;
            OP_CIPHER: q_pop = out_free;
            default:   q_pop = 1'b0;
          endcase
        end
      end
      S_EMIT:  q_pop = out_free;
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= S_IDLE;
      rnd_r       <= '0;
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop && head.op != OP_LOAD) begin
        out_valid_r <= 1'b1;
        out_data_r  <= dout;
        out_bytes_r <= head.count;
      end
      case (fsm_r)
        S_IDLE: begin
          if (!q_stat.empty) begin
            if (head.op == OP_LOAD) begin
              for (int i = 0; i < NUM_CFG; i++) begin
                state_r[2*i]   <= cfg_regs[i][31:0];
                state_r[2*i+1] <= cfg_regs[i][63:32];
              end
            end else if (head.op == OP_PERMUTE) begin
              fsm_r <= S_ROUND;
              rnd_r <= '0;
            end
          end
        end
        S_ROUND: begin
          state_r <= chacha_round(state_r, rnd_r[0]);
          if (rnd_r == ROUND_W'(ROUNDS - 1)) begin
            fsm_r <= S_EMIT;
          end else begin
            rnd_r <= rnd_r + 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            fsm_r <= S_IDLE;
          end
        end
        default: fsm_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data_out    = out_data_r;
  assign out_valid_bytes = out_bytes_r;

endmodule
`default_nettype wire

// ----- rtl/chacha_chained_keystream_xor.sv -----
`default_nettype none
// A cipher word whose keystream is already available passes through the queue to the
// output register; a word that starts a new block first waits for the 20 rounds.
// Cipher words leave at one word per cycle within a block while out_stall is low; a new
// block waits on the single round unit, which does one round per cycle. Loads give no result.
// Reset (rst_n low, synchronous) clears the registers, the state words and the queue.
module chacha_chained_keystream_xor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [63:0] in_data_in,
  input  wire logic [3:0]  in_byte_count,
  input  wire logic        in_first_of_message,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_data_out,
  output logic [3:0]       out_valid_bytes
);
  import cck_pkg::*;

  cfg_regs_t cfg_r;
  q_status_t q_stat;
  q_item_t   q_item, q_head;
  logic      q_push, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  cck_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_data_in          (in_data_in),
    .in_byte_count       (in_byte_count),
    .in_first_of_message (in_first_of_message),
    .q_stat              (q_stat),
    .q_push              (q_push),
    .q_item              (q_item)
  );

  cck_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  cck_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_regs        (cfg_r),
    .head            (q_head),
    .q_stat          (q_stat),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data_out    (out_data_out),
    .out_valid_bytes (out_valid_bytes)
  );

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("Queue popped while empty.");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("Queue pushed while full.");

  a_result_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(q_pop) && $past(q_head.op) != OP_LOAD)
    else $error("Result appeared without a cipher item leaving the queue.");
`endif

endmodule
`default_nettype wire
